@@ hw/rtl/ring_fault_diagnosis_defines.svh @@
// ----------------------------------------------------------------------------
// Ring fault diagnosis - assertion macros
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RING_FAULT_DIAGNOSIS_DEFINES_SVH
`define RING_FAULT_DIAGNOSIS_DEFINES_SVH

// same-cycle implication
`define RFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring fault diagnosis package
// View codes, event kinds, stream widths and the result layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int MAX_NODES_DEF  = 16;
  localparam int CFG_W          = 5;
  localparam int NODE_W         = 4;
  localparam int FUNC_W         = 2;
  localparam int IN_W           = 8;
  localparam int OUT_W          = 48;
  localparam int ROW_VIEW_W     = 32;
  localparam int SKIP_W         = 4;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd8;

  localparam logic [1:0] V_CORRECT = 2'd0;
  localparam logic [1:0] V_FAULTY  = 2'd1;
  localparam logic [1:0] V_UNKNOWN = 2'd2;

  localparam logic [FUNC_W-1:0] FUNC_TEST    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FAULT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RECOVER = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

  // result, lowest field last
  typedef struct packed {
    logic [OUT_W-ROW_VIEW_W-SKIP_W-NODE_W-3:0] pad;
    logic [ROW_VIEW_W-1:0]                     row_view;
    logic [SKIP_W-1:0]                         faulty_skipped;
    logic                                      found_correct;
    logic                                      tester_faulty;
    logic [NODE_W-1:0]                         node_out;
  } res_t;

endpackage

@@ hw/rtl/ring_fault_diagnosis.sv @@
// ----------------------------------------------------------------------------
// Ring fault diagnosis
// Per-node fault flags and a view matrix updated by test, fault and recovery
// events; an in-ring request of a used kind returns the concerned node's row.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake, tdata = func[1:0], node[5:2].
//   out_* : one result per request, held until taken.
//   cfg_* : node count write, always ready; write only while idle.
// Sequence: fault, recovery and faulty-tester requests go through S_CHECK,
//   S_RDCAP and S_DONE, out-of-ring requests through S_CHECK and S_DONE.
//   A test that finds a correct successor walks the faulty ones in S_WALK,
//   reads its row in S_SRCCAP, merges it in S_COPY and writes back in S_WB;
//   a walk that wraps goes to S_WB. One row entry per cycle through the
//   walk and the copy; the next request is taken once the result is loaded.
// Reset: flags cleared, node count 8, then a clearing pass writes the
//   MAX_NODES initial rows; in_tready stays low meanwhile.
// Stall: processing continues while a result waits; a finished request
//   waits for the output register, and in_tready is low until it is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ring_fault_diagnosis_defines.svh"

module ring_fault_diagnosis #(
  parameter int MAX_NODES = rfd_pkg::MAX_NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [rfd_pkg::IN_W-1:0] in_tdata,   // func[1:0], node[5:2]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // node_out[3:0], tester_faulty[4], found_correct[5], faulty_skipped[9:6],
  // row_view[41:10]
  output logic [rfd_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rfd_pkg::CFG_W-1:0] cfg_data
);

  import rfd_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ROW_W = 2 * MAX_NODES;
  localparam int SHOW  = (MAX_NODES < 16) ? MAX_NODES : 16;

  localparam logic [CW-1:0]    N_MIN   = CW'(2);
  localparam logic [CW-1:0]    N_MAX   = CW'(MAX_NODES);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_NODES - 1);
  localparam logic [SKIP_W-1:0] SKIP_SAT = {SKIP_W{1'b1}};

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_RDCAP  = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_SRCCAP = 4'd5;
  localparam logic [3:0] S_COPY   = 4'd6;
  localparam logic [3:0] S_WB     = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     cfg_r, cfg_nxt;
  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic [CW-1:0]        t_r, t_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        nx_r, nx_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic                 tf_r, tf_nxt;
  logic                 found_r, found_nxt;
  logic [SKIP_W-1:0]    skip_r, skip_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [ROW_W-1:0]     src_r, src_nxt;
  logic [MAX_NODES-1:0] tested_r, tested_nxt;
  logic [MAX_NODES-1:0] flags_r, flags_nxt;
  logic [IDX_W-1:0]     clr_r, clr_nxt;
  res_t                 out_r, out_nxt;
  logic                 out_vld_r, out_vld_nxt;

  logic [CW-1:0]        ring_n;
  logic [CW-1:0]        cfg_ext;
  logic [CW-1:0]        nx_inc;
  logic [CW-1:0]        t_inc;
  logic [IDX_W-1:0]     t_idx, nx_idx, j_idx, flag_idx;
  logic                 flag_bit;
  logic [ROW_W-1:0]     init_row;
  logic [ROW_VIEW_W-1:0] row_show;

  logic                 wr_en, rd_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [ROW_W-1:0]     wr_data, rd_data;

  rfd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES),
    .AW    (IDX_W)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  assign cfg_ext = CW'(cfg_r);
  assign ring_n  = (cfg_ext < N_MIN) ? N_MIN : ((cfg_ext > N_MAX) ? N_MAX : cfg_ext);

  assign t_idx    = t_r[IDX_W-1:0];
  assign nx_idx   = nx_r[IDX_W-1:0];
  assign j_idx    = j_r[IDX_W-1:0];
  assign flag_idx = (state_r == S_WALK) ? nx_idx : t_idx;
  assign flag_bit = flags_r[flag_idx];
  assign t_inc    = t_r + CW'(1);
  assign nx_inc   = nx_r + CW'(1);

  always_comb begin
    init_row = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      init_row[2*k +: 2] = (IDX_W'(k) == clr_r) ? V_CORRECT : V_UNKNOWN;
    end
  end

  always_comb begin
    row_show = '0;
    for (int k = 0; k < SHOW; k++) begin
      row_show[2*k +: 2] = row_r[2*k +: 2];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cfg_nxt     = cfg_r;
    func_nxt    = func_r;
    t_nxt       = t_r;
    n_nxt       = n_r;
    nx_nxt      = nx_r;
    j_nxt       = j_r;
    tf_nxt      = tf_r;
    found_nxt   = found_r;
    skip_nxt    = skip_r;
    row_nxt     = row_r;
    src_nxt     = src_r;
    tested_nxt  = tested_r;
    flags_nxt   = flags_r;
    clr_nxt     = clr_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    wr_en       = 1'b0;
    wr_addr     = t_idx;
    wr_data     = row_r;
    rd_en       = 1'b0;
    rd_addr     = t_idx;

    if (cfg_valid) begin
      cfg_nxt = cfg_data;
    end
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = init_row;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_TOP) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tdata[FUNC_W-1:0];
          t_nxt     = CW'(in_tdata[FUNC_W +: NODE_W]);
          n_nxt     = ring_n;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        tf_nxt    = 1'b0;
        found_nxt = 1'b0;
        skip_nxt  = '0;
        if (t_r >= n_r || func_r == FUNC_UNUSED) begin
          row_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          case (func_r)
            FUNC_FAULT:   flags_nxt[t_idx] = 1'b1;
            FUNC_RECOVER: flags_nxt[t_idx] = 1'b0;
            default:      tf_nxt = flag_bit;
          endcase
          rd_en     = 1'b1;
          rd_addr   = t_idx;
          state_nxt = S_RDCAP;
        end
      end
      S_RDCAP: begin
        row_nxt = rd_data;
        if (func_r != FUNC_TEST || tf_r) begin
          state_nxt = S_DONE;
        end else begin
          nx_nxt     = (t_inc == n_r) ? '0 : t_inc;
          tested_nxt = '0;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (nx_r == t_r) begin
          state_nxt = S_WB;
        end else if (flag_bit) begin
          row_nxt[2*nx_idx +: 2] = V_FAULTY;
          tested_nxt[nx_idx]     = 1'b1;
          if (skip_r != SKIP_SAT) begin
            skip_nxt = skip_r + SKIP_W'(1);
          end
          nx_nxt = (nx_inc == n_r) ? '0 : nx_inc;
        end else begin
          found_nxt              = 1'b1;
          row_nxt[2*nx_idx +: 2] = V_CORRECT;
          tested_nxt[nx_idx]     = 1'b1;
          rd_en                  = 1'b1;
          rd_addr                = nx_idx;
          state_nxt              = S_SRCCAP;
        end
      end
      S_SRCCAP: begin
        src_nxt   = rd_data;
        j_nxt     = '0;
        state_nxt = S_COPY;
      end
      S_COPY: begin
        if (j_r == n_r) begin
          state_nxt = S_WB;
        end else begin
          if (j_r != t_r && !tested_r[j_idx]) begin
            row_nxt[2*j_idx +: 2] = src_r[2*j_idx +: 2];
          end
          j_nxt = j_r + CW'(1);
        end
      end
      S_WB: begin
        wr_en     = 1'b1;
        wr_addr   = t_idx;
        wr_data   = row_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_nxt.pad            = '0;
          out_nxt.node_out       = t_r[NODE_W-1:0];
          out_nxt.tester_faulty  = tf_r;
          out_nxt.found_correct  = found_r;
          out_nxt.faulty_skipped = skip_r;
          out_nxt.row_view       = row_show;
          out_vld_nxt            = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cfg_r     <= NODE_COUNT_RST;
      flags_r   <= '0;
      clr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cfg_r     <= cfg_nxt;
      flags_r   <= flags_nxt;
      clr_r     <= clr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    t_r      <= t_nxt;
    n_r      <= n_nxt;
    nx_r     <= nx_nxt;
    j_r      <= j_nxt;
    tf_r     <= tf_nxt;
    found_r  <= found_nxt;
    skip_r   <= skip_nxt;
    row_r    <= row_nxt;
    src_r    <= src_nxt;
    tested_r <= tested_nxt;
    out_r    <= out_nxt;
  end

  `RFD_ASSERT_IMP(a_no_accept_in_clear, state_r == S_CLR, !in_tready, "request taken during clear")
  `RFD_ASSERT_NXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r == S_CHECK, "accept did not start")
  `RFD_ASSERT_IMP(a_faulty_not_found, out_vld_r, !(out_r.tester_faulty && out_r.found_correct), "faulty tester walked")
  `RFD_ASSERT_IMP(a_skip_in_ring, out_vld_r, CW'(out_r.faulty_skipped) < n_r, "skip count exceeds ring")

endmodule

@@ hw/rtl/rfd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring fault diagnosis testbench
// Drives test, fault and recovery requests through the stream ports across
// several ring sizes, mirrors the flags and the view matrix in a local model
// and compares every result field by field, under random back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import rfd_pkg::*;

  localparam int               NODES       = MAX_NODES_DEF;
  localparam int               PHASES      = 9;
  localparam int               PHASE_REQS  = 200;
  localparam int               TAIL_CYCLES = 40;
  localparam int               MAX_REPORTS = 10;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [NODE_W-1:0] nd;
    bit                typed;
    res_t              want;
  } step_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;   // func[1:0], node[5:2]
  logic                out_tvalid;
  logic                out_tready;
  // node_out[3:0], tester_faulty[4], found_correct[5], faulty_skipped[9:6],
  // row_view[41:10]
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;

  // local copy of the diagnosis state
  bit                  fault_flag_q [NODES];
  logic [1:0]          view_q [NODES][NODES];
  logic [CFG_W-1:0]    node_count_q;

  res_t                pending_rows [$];
  step_t               directed_tab [$];
  int                  snd_idle_pct;
  int                  rcv_idle_pct;
  int                  n_sent;
  int                  n_checked;
  int                  n_fail;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ring_fault_diagnosis u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic int ring_nodes();
    int n;
    n = node_count_q;
    if (n < 2) n = 2;
    if (n > NODES) n = NODES;
    return n;
  endfunction

  function automatic res_t mk_row(input int nd, input bit tf, input bit fc,
                                  input int sk, input logic [31:0] row);
    res_t r;
    r = '0;
    r.node_out       = nd[NODE_W-1:0];
    r.tester_faulty  = tf;
    r.found_correct  = fc;
    r.faulty_skipped = sk[SKIP_W-1:0];
    r.row_view       = row;
    return r;
  endfunction

  // apply one request to the local state and return the result it yields
  function automatic res_t diagnose_event(input logic [FUNC_W-1:0] fn,
                                          input logic [NODE_W-1:0] nd);
    res_t r;
    int   n;
    int   nx;
    int   skip;
    bit   tested [NODES];
    r = '0;
    r.node_out = nd;
    n = ring_nodes();
    if (int'(nd) < n && fn != FUNC_UNUSED) begin
      case (fn)
        FUNC_FAULT:   fault_flag_q[nd] = 1'b1;
        FUNC_RECOVER: fault_flag_q[nd] = 1'b0;
        default: begin
          if (fault_flag_q[nd]) begin
            r.tester_faulty = 1'b1;
          end else begin
            foreach (tested[j]) tested[j] = 1'b0;
            skip = 0;
            nx = (nd + 1) % n;
            while (fault_flag_q[nx]) begin
              view_q[nd][nx] = V_FAULTY;
              tested[nx] = 1'b1;
              if (skip < 15) skip++;
              nx = (nx + 1) % n;
              if (nx == int'(nd)) break;
            end
            if (nx != int'(nd)) begin
              r.found_correct = 1'b1;
              view_q[nd][nx] = V_CORRECT;
              tested[nx] = 1'b1;
              for (int j = 0; j < n; j++)
                if (j != int'(nd) && !tested[j]) view_q[nd][j] = view_q[nx][j];
            end
            r.faulty_skipped = skip[SKIP_W-1:0];
          end
        end
      endcase
      for (int j = 0; j < NODES && j < 16; j++) r.row_view[2*j +: 2] = view_q[nd][j];
    end
    return r;
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] fn, input int nd, input bit typed,
                         input res_t want);
    step_t s;
    s.fn    = fn;
    s.nd    = nd[NODE_W-1:0];
    s.typed = typed;
    s.want  = want;
    directed_tab.push_back(s);
  endtask

  task automatic send_event(input logic [FUNC_W-1:0] fn, input logic [NODE_W-1:0] nd,
                            input bit typed, input res_t want);
    res_t pred;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, nd, fn};
    do @(posedge clk); while (!in_tready);
    pred = diagnose_event(fn, nd);
    pending_rows.push_back(typed ? want : pred);
    n_sent++;
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_count_q = v;
  endtask

  // result side
  initial begin
    res_t got;
    res_t exp;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_rows.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("unexpected result node %0d data %h", got.node_out, out_tdata);
        end else begin
          exp = pending_rows.pop_front();
          n_checked++;
          if (got.node_out != exp.node_out || got.tester_faulty != exp.tester_faulty ||
              got.found_correct != exp.found_correct ||
              got.faulty_skipped != exp.faulty_skipped ||
              got.row_view != exp.row_view || got.pad != exp.pad) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display("mismatch: exp node=%0d tf=%0b fc=%0b sk=%0d row=%h pad=%h",
                       exp.node_out, exp.tester_faulty, exp.found_correct,
                       exp.faulty_skipped, exp.row_view, exp.pad,
                       " | got node=%0d tf=%0b fc=%0b sk=%0d row=%h pad=%h",
                       got.node_out, got.tester_faulty, got.found_correct,
                       got.faulty_skipped, got.row_view, got.pad);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // request side
  initial begin
    logic [CFG_W-1:0]  cfg_tab [PHASES];
    int                fault_pct [PHASES];
    logic [FUNC_W-1:0] fn;
    logic [NODE_W-1:0] nd;
    int                n;
    int                done;
    int                r;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    n_sent = 0;
    n_checked = 0;
    n_fail = 0;
    snd_idle_pct = 13;
    rcv_idle_pct = 67;
    node_count_q = NODE_COUNT_RST;
    foreach (fault_flag_q[i]) fault_flag_q[i] = 1'b0;
    foreach (view_q[i, j]) view_q[i][j] = (i == j) ? V_CORRECT : V_UNKNOWN;
    cfg_tab   = '{5'd0, 5'd31, 5'd16, 5'd2, 5'd1, 5'd17, 5'd12, 5'd16, 5'd0};
    cfg_tab[PHASES-1] = $urandom_range(0, 31);
    fault_pct = '{50, 85, 60, 50, 40, 90, 70, 30, 60};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ring of 8 after reset
    add_row(FUNC_TEST,    0, 1, mk_row(0, 0, 1, 0, 32'hAAAAAAA0));
    add_row(FUNC_FAULT,   3, 1, mk_row(3, 0, 0, 0, 32'hAAAAAA2A));
    add_row(FUNC_TEST,    3, 1, mk_row(3, 1, 0, 0, 32'hAAAAAA2A));
    add_row(FUNC_UNUSED,  5, 1, mk_row(5, 0, 0, 0, 32'h0));
    add_row(FUNC_TEST,   15, 1, mk_row(15, 0, 0, 0, 32'h0));
    add_row(FUNC_TEST,    2, 0, '0);
    add_row(FUNC_RECOVER, 3, 0, '0);
    add_row(FUNC_RECOVER, 3, 0, '0);
    add_row(FUNC_TEST,    7, 0, '0);
    for (int k = 1; k < 8; k++) add_row(FUNC_FAULT, k, 0, '0);
    add_row(FUNC_TEST,    0, 0, '0);
    add_row(FUNC_FAULT,   0, 0, '0);
    add_row(FUNC_RECOVER, 4, 0, '0);
    add_row(FUNC_TEST,    4, 0, '0);
    add_row(FUNC_RECOVER, 5, 0, '0);
    add_row(FUNC_TEST,    4, 0, '0);
    add_row(FUNC_FAULT,  15, 1, mk_row(15, 0, 0, 0, 32'h0));
    add_row(FUNC_RECOVER, 0, 0, '0);
    foreach (directed_tab[i])
      send_event(directed_tab[i].fn, directed_tab[i].nd, directed_tab[i].typed,
                 directed_tab[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_node_count(cfg_tab[ph]);
      snd_idle_pct = (ph < 3) ? 13 : (ph < 6) ? 67 : 0;
      rcv_idle_pct = (ph < 3) ? 67 : (ph < 6) ? 13 : 0;
      n = ring_nodes();
      done = 0;
      while (done < PHASE_REQS) begin
        r = $urandom_range(0, 99);
        if (r < 3) fn = FUNC_UNUSED;
        else if (r < 50) fn = FUNC_TEST;
        else fn = ($urandom_range(0, 99) < fault_pct[ph]) ? FUNC_FAULT : FUNC_RECOVER;
        if ($urandom_range(0, 9) == 0) nd = $urandom_range(0, 15);
        else nd = $urandom_range(0, n - 1);
        done++;
        send_event(fn, nd, 0, '0);
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d requests (%0d directed), %0d results checked", n_sent,
             directed_tab.size(), n_checked);
    $display("tb: ring sizes 2..16 incl. saturated counts, sender/receiver stalls mixed");
    if (n_fail == 0 && pending_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("tb: %0d failures, %0d results outstanding", n_fail, pending_rows.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
